FILE: sv/rppx_pkg.sv
// ----------------------------------------------------------------------------
// rppx_pkg: shared types and constants for the pivot rotation pipeline
// Fixed-point formats, phase multipliers and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rppx_pkg;

  localparam int unsigned CordicStepsDef = 18;
  localparam int unsigned AtanCount      = 30;

  // register map (index into the register list)
  localparam logic RegAngleUnit = 1'b0;

  // angle to phase multipliers, 2^47/pi and 2^48/360
  localparam logic [45:0] MulRadians = 46'h28BE60DB9391;
  localparam logic [45:0] MulDegrees = 46'd781874935307;

  // CORDIC start value, gain compensated, Q2.30
  localparam logic signed [32:0] CordicX0 = 33'sd652032874;

  // one CORDIC lane: x, y in Q2.30, residual angle z, quadrant
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic [1:0]         q;
  } cor_t;

  // cosine and sine in Q28
  typedef struct packed {
    logic signed [30:0] c;
    logic signed [30:0] s;
  } cs_t;

  // atan(2^-i) in turn units (2^32 per turn), truncated
  function automatic logic signed [31:0] atan_turns(input int unsigned i);
    logic signed [31:0] v;
    unique case (i)
      0:  v = 32'sh20000000;
      1:  v = 32'sh12E4051D;
      2:  v = 32'sh09FB385B;
      3:  v = 32'sh051111D4;
      4:  v = 32'sh028B0D43;
      5:  v = 32'sh0145D7E1;
      6:  v = 32'sh00A2F61E;
      7:  v = 32'sh00517C55;
      8:  v = 32'sh0028BE53;
      9:  v = 32'sh00145F2E;
      10: v = 32'sh000A2F98;
      11: v = 32'sh000517CC;
      12: v = 32'sh00028BE6;
      13: v = 32'sh000145F3;
      14: v = 32'sh0000A2F9;
      15: v = 32'sh0000517C;
      16: v = 32'sh000028BE;
      17: v = 32'sh0000145F;
      18: v = 32'sh00000A2F;
      19: v = 32'sh00000517;
      20: v = 32'sh0000028B;
      21: v = 32'sh00000145;
      22: v = 32'sh000000A2;
      23: v = 32'sh00000051;
      24: v = 32'sh00000028;
      25: v = 32'sh00000014;
      26: v = 32'sh0000000A;
      27: v = 32'sh00000005;
      28: v = 32'sh00000002;
      29: v = 32'sh00000001;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/rotate_point_about_pivot_xyz.sv
// ----------------------------------------------------------------------------
// rotate_point_about_pivot_xyz: rotate a Q16.16 point about a pivot (X, Y, Z)
// Fully pipelined; one word in and one word out per clock when not stalled.
// ----------------------------------------------------------------------------
// Each input word carries a point, a pivot and three Euler angles, all
// signed Q16.16. The point is moved to the pivot, rotated about X, then Y,
// then Z, moved back and saturated to 32 bits; tuser flags saturation.
// Angles are radians or degrees per the angle_unit register (APB offset 0,
// bit 0); change it only while the pipeline is empty. The pipeline takes a
// new word every cycle unless the output stalls and has these stages: one
// multiply stage for the phase, one for quadrant reduction, one per CORDIC
// iteration (three lanes side by side), one for rounding and quadrant
// mapping, two per plane rotation (multiply, then sum and round) and one
// output register with saturation. The whole pipeline advances together;
// it holds while the output word is not taken.
// ----------------------------------------------------------------------------
module rotate_point_about_pivot_xyz #(
  parameter int unsigned CORDIC_STEPS = rppx_pkg::CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // in: point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
  //     angle_x, angle_y, angle_z (32 bits each, lowest first)
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  // out: result_x, result_y, result_z (32 bits each, lowest first)
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,
  // out: saturated
  output logic         m_axis_tuser,
  // APB register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned NS = (CORDIC_STEPS < rppx_pkg::AtanCount) ?
                               CORDIC_STEPS : rppx_pkg::AtanCount;

  // ---------------------------------------------------------------- config
  logic unit_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rppx_pkg::RegAngleUnit) ? {31'd0, unit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == rppx_pkg::RegAngleUnit) begin
      unit_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------- flow
  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------- stage 1
  // pivot differences and the two halves of the angle-to-phase product
  logic [45:0]        mul_sel;
  logic signed [32:0] dif [3];
  logic signed [55:0] plo [3];
  logic signed [55:0] phi [3];

  logic               s1_vld_q;
  logic signed [32:0] s1_dif_q [3];
  logic signed [31:0] s1_piv_q [3];
  logic signed [55:0] s1_plo_q [3];
  logic signed [55:0] s1_phi_q [3];

  assign mul_sel = unit_q ? rppx_pkg::MulDegrees : rppx_pkg::MulRadians;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k] = {s_axis_tdata[32*k+31], s_axis_tdata[32*k +: 32]} -
               {s_axis_tdata[32*(k+3)+31], s_axis_tdata[32*(k+3) +: 32]};
      plo[k] = $signed(s_axis_tdata[32*(k+6) +: 32]) * $signed({1'b0, mul_sel[22:0]});
      phi[k] = $signed(s_axis_tdata[32*(k+6) +: 32]) * $signed({1'b0, mul_sel[45:23]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_dif_q[k] <= dif[k];
        s1_piv_q[k] <= s_axis_tdata[32*(k+3) +: 32];
        s1_plo_q[k] <= plo[k];
        s1_phi_q[k] <= phi[k];
      end
    end
  end

  // ---------------------------------------------------------------- CORDIC
  // index 0: phase reduced to quadrant plus residual; index k+1: after step k
  logic             cor_vld_q [NS+1];
  rppx_pkg::cor_t   cor_q     [NS+1][3];
  logic signed [32:0] cdif_q  [NS+1][3];
  logic signed [31:0] cpiv_q  [NS+1][3];

  rppx_pkg::cor_t   cor0 [3];

  always_comb begin
    logic [63:0] sum;
    logic [2:0]  top;
    logic [31:0] sh;
    for (int k = 0; k < 3; k++) begin
      sum = {{8{s1_plo_q[k][55]}}, s1_plo_q[k]} + {s1_phi_q[k][40:0], 23'd0};
      // add one eighth turn so the residual is centered on the quadrant
      top = sum[63:61] + 3'd1;
      sh  = {top, sum[60:32]};
      cor0[k].x = rppx_pkg::CordicX0;
      cor0[k].y = '0;
      cor0[k].z = {{2{~sh[29]}}, ~sh[29], sh[28:0]};
      cor0[k].q = sh[31:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cor_vld_q[0] <= 1'b0;
    end else if (en) begin
      cor_vld_q[0] <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cor_q[0][k]  <= cor0[k];
        cdif_q[0][k] <= s1_dif_q[k];
        cpiv_q[0][k] <= s1_piv_q[k];
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam logic signed [31:0] Atan = rppx_pkg::atan_turns(i);
    rppx_pkg::cor_t nxt [3];

    always_comb begin
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      for (int k = 0; k < 3; k++) begin
        dx = cor_q[i][k].y >>> i;
        dy = cor_q[i][k].x >>> i;
        nxt[k].q = cor_q[i][k].q;
        if (!cor_q[i][k].z[31]) begin
          nxt[k].x = cor_q[i][k].x - dx;
          nxt[k].y = cor_q[i][k].y + dy;
          nxt[k].z = cor_q[i][k].z - Atan;
        end else begin
          nxt[k].x = cor_q[i][k].x + dx;
          nxt[k].y = cor_q[i][k].y - dy;
          nxt[k].z = cor_q[i][k].z + Atan;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cor_vld_q[i+1] <= 1'b0;
      end else if (en) begin
        cor_vld_q[i+1] <= cor_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          cor_q[i+1][k]  <= nxt[k];
          cdif_q[i+1][k] <= cdif_q[i][k];
          cpiv_q[i+1][k] <= cpiv_q[i][k];
        end
      end
    end
  end

  // ---------------------------------------------------------------- sin/cos
  // round to Q28 and map the quadrant; coordinates widen to 35 bits here
  rppx_pkg::cs_t cs0 [3];

  always_comb begin
    logic signed [33:0] xr;
    logic signed [33:0] yr;
    logic signed [30:0] cc;
    logic signed [30:0] ss;
    for (int k = 0; k < 3; k++) begin
      xr = {cor_q[NS][k].x[32], cor_q[NS][k].x} + 34'sd2;
      yr = {cor_q[NS][k].y[32], cor_q[NS][k].y} + 34'sd2;
      cc = xr[32:2];
      ss = yr[32:2];
      unique case (cor_q[NS][k].q)
        2'd0: begin cs0[k].c = cc;  cs0[k].s = ss;  end
        2'd1: begin cs0[k].c = -ss; cs0[k].s = cc;  end
        2'd2: begin cs0[k].c = -cc; cs0[k].s = -ss; end
        default: begin cs0[k].c = ss; cs0[k].s = -cc; end
      endcase
    end
  end

  // rotation stages: index 0 holds sin/cos, 2p+1 products, 2p+2 plane p done
  logic               pl_vld_q [7];
  rppx_pkg::cs_t      pl_cs_q  [7][3];
  logic signed [34:0] pl_crd_q [7][3];
  logic signed [31:0] pl_piv_q [7][3];
  logic signed [65:0] prod_q   [3][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_vld_q[0] <= 1'b0;
    end else if (en) begin
      pl_vld_q[0] <= cor_vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pl_cs_q[0][k]  <= cs0[k];
        pl_crd_q[0][k] <= {{2{cdif_q[NS][k][32]}}, cdif_q[NS][k]};
        pl_piv_q[0][k] <= cpiv_q[NS][k];
      end
    end
  end

  for (genvar p = 0; p < 3; p++) begin : g_plane
    localparam int unsigned IA = (p + 1) % 3;
    localparam int unsigned IB = (p + 2) % 3;
    localparam int unsigned SM = 2 * p + 1;
    logic signed [66:0] na;
    logic signed [66:0] nb;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pl_vld_q[SM]   <= 1'b0;
        pl_vld_q[SM+1] <= 1'b0;
      end else if (en) begin
        pl_vld_q[SM]   <= pl_vld_q[SM-1];
        pl_vld_q[SM+1] <= pl_vld_q[SM];
      end
    end

    // a*c, b*s, a*s, b*c
    always_ff @(posedge clk_i) begin
      if (en) begin
        prod_q[p][0] <= pl_crd_q[SM-1][IA] * pl_cs_q[SM-1][p].c;
        prod_q[p][1] <= pl_crd_q[SM-1][IB] * pl_cs_q[SM-1][p].s;
        prod_q[p][2] <= pl_crd_q[SM-1][IA] * pl_cs_q[SM-1][p].s;
        prod_q[p][3] <= pl_crd_q[SM-1][IB] * pl_cs_q[SM-1][p].c;
        for (int k = 0; k < 3; k++) begin
          pl_cs_q[SM][k]  <= pl_cs_q[SM-1][k];
          pl_crd_q[SM][k] <= pl_crd_q[SM-1][k];
          pl_piv_q[SM][k] <= pl_piv_q[SM-1][k];
        end
      end
    end

    // round half up, floor shift back to Q16.16
    assign na = {prod_q[p][0][65], prod_q[p][0]} - {prod_q[p][1][65], prod_q[p][1]} +
                67'sd134217728;
    assign nb = {prod_q[p][2][65], prod_q[p][2]} + {prod_q[p][3][65], prod_q[p][3]} +
                67'sd134217728;

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          pl_cs_q[SM+1][k]  <= pl_cs_q[SM][k];
          pl_piv_q[SM+1][k] <= pl_piv_q[SM][k];
        end
        pl_crd_q[SM+1][p]  <= pl_crd_q[SM][p];
        pl_crd_q[SM+1][IA] <= na[62:28];
        pl_crd_q[SM+1][IB] <= nb[62:28];
      end
    end
  end

  // ---------------------------------------------------------------- output
  localparam logic signed [35:0] SatHi = 36'sd2147483647;
  localparam logic signed [35:0] SatLo = -36'sd2147483648;

  logic [31:0] res_d [3];
  logic        sat_d;
  logic [31:0] res_q [3];
  logic        sat_q;

  always_comb begin
    logic signed [35:0] sum;
    sat_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sum = {pl_crd_q[6][k][34], pl_crd_q[6][k]} +
            {{4{pl_piv_q[6][k][31]}}, pl_piv_q[6][k]};
      if (sum > SatHi) begin
        res_d[k] = 32'h7FFFFFFF;
        sat_d    = 1'b1;
      end else if (sum < SatLo) begin
        res_d[k] = 32'h80000000;
        sat_d    = 1'b1;
      end else begin
        res_d[k] = sum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= pl_vld_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {res_q[2], res_q[1], res_q[0]};
  assign m_axis_tuser  = sat_q;

endmodule

FILE: tb/rppx_checker.sv
// ----------------------------------------------------------------------------
// rppx_checker: scoreboard for the pivot rotation pipeline
// Predicts each output word from accepted input words and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rppx_checker (
  input  logic         clk_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         angle_unit_i,
  output int           errors_o,
  output int           pending_o,
  output int           seen_o,
  output int           sat_seen_o
);

  typedef struct {
    logic [31:0] rx, ry, rz;
    logic        sat;
  } rot_word_t;

  rot_word_t rot_expected_q[$];

  localparam logic signed [31:0] AtanTab [30] = '{
    32'sh20000000, 32'sh12E4051D, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2E,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
    32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
    32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051, 32'sh00000028,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000002, 32'sh00000001};

  // cos/sin in Q28 for one angle
  function automatic void trig_of(input logic [31:0] ang, input logic unit,
                                  output longint c, output longint s);
    longint a, x, y, z, dx, dy, cc, ss;
    logic [63:0] prod;
    logic [31:0] ph, sh;
    logic [1:0]  q;
    a = longint'($signed(ang));
    prod = a * (unit ? 64'd781874935307 : 64'h28BE60DB9391);
    ph = prod[63:32];
    sh = ph + 32'h20000000;
    q = sh[31:30];
    z = longint'({2'b00, sh[29:0]}) - 64'sh20000000;
    x = 652032874; y = 0;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    cc = (x + 2) >>> 2; ss = (y + 2) >>> 2;
    unique case (q)
      2'd0: begin c = cc; s = ss; end
      2'd1: begin c = -ss; s = cc; end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  function automatic void plane(inout longint a, inout longint b, input longint c,
                                input longint s);
    longint na, nb;
    na = (a * c - b * s + (64'sd1 <<< 27)) >>> 28;
    nb = (a * s + b * c + (64'sd1 <<< 27)) >>> 28;
    a = na; b = nb;
  endfunction

  function automatic logic [31:0] clip32(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin sat = 1'b1; return 32'h7FFFFFFF; end
    if (v < -64'sd2147483648) begin sat = 1'b1; return 32'h80000000; end
    return v[31:0];
  endfunction

  function automatic rot_word_t predict_rotation(input logic [287:0] d, input logic unit);
    rot_word_t w;
    longint px, py, pz, x, y, z, c, s;
    px = $signed(d[127:96]); py = $signed(d[159:128]); pz = $signed(d[191:160]);
    x = longint'($signed(d[31:0])) - px;
    y = longint'($signed(d[63:32])) - py;
    z = longint'($signed(d[95:64])) - pz;
    trig_of(d[223:192], unit, c, s); plane(y, z, c, s);
    trig_of(d[255:224], unit, c, s); plane(z, x, c, s);
    trig_of(d[287:256], unit, c, s); plane(x, y, c, s);
    w.sat = 1'b0;
    w.rx = clip32(x + px, w.sat);
    w.ry = clip32(y + py, w.sat);
    w.rz = clip32(z + pz, w.sat);
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h (word %0d)", what, got, want, seen_o);
    errors_o++;
  endtask

  initial begin
    errors_o = 0; seen_o = 0; sat_seen_o = 0;
  end
  assign pending_o = rot_expected_q.size();

  always @(posedge clk_i) begin
    rot_word_t w;
    if (s_axis_tvalid && s_axis_tready)
      rot_expected_q.push_back(predict_rotation(s_axis_tdata, angle_unit_i));
    if (m_axis_tvalid && m_axis_tready) begin
      if (rot_expected_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[31:0], 32'h0);
      end else begin
        w = rot_expected_q.pop_front();
        if (m_axis_tdata[31:0] !== w.rx) report_mismatch("result_x", m_axis_tdata[31:0], w.rx);
        if (m_axis_tdata[63:32] !== w.ry) report_mismatch("result_y", m_axis_tdata[63:32], w.ry);
        if (m_axis_tdata[95:64] !== w.rz) report_mismatch("result_z", m_axis_tdata[95:64], w.rz);
        if (m_axis_tuser !== w.sat) report_mismatch("saturated", m_axis_tuser, w.sat);
        if (w.sat) sat_seen_o++;
      end
      seen_o++;
    end
  end

endmodule

FILE: tb/tb_rotate_point_about_pivot_xyz.sv
// ----------------------------------------------------------------------------
// tb_rotate_point_about_pivot_xyz: stream test of the pivot rotation block
// Directed corner words, then random words in both angle units under
// varying sender gaps and receiver stalls; a checker scores every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_rotate_point_about_pivot_xyz;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  // point_x, point_y, point_z, pivot_x, pivot_y, pivot_z, angle_x, angle_y, angle_z
  logic [287:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  // result_x, result_y, result_z
  logic [95:0]  m_axis_tdata;
  // saturated
  logic         m_axis_tuser;
  logic         psel, penable, pwrite, pready;
  logic [2:0]   paddr;
  logic [31:0]  pwdata, prdata;

  logic angle_unit;     // shadow of the register for the checker
  int   errors, pending, seen, sat_seen;
  int   send_idle_pct, recv_stall_pct;
  bit   hold_recv;      // long receiver hold-off request
  int   words_sent;

  rotate_point_about_pivot_xyz uut (.*);

  rppx_checker chk (
    .clk_i, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .angle_unit_i(angle_unit), .errors_o(errors), .pending_o(pending),
    .seen_o(seen), .sat_seen_o(sat_seen));

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #3ms;
    $display("timeout, %0d words outstanding", pending);
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long hold when asked
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_recv) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(negedge clk_i);
        hold_recv = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait for an empty pipeline, then set the unit
  task automatic set_unit(input logic unit);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    apb_write({rppx_pkg::RegAngleUnit, 2'b00},
              {$urandom_range(1) ? 31'h7FFF_FFFF : 31'h0, unit});
    angle_unit = unit;
  endtask

  // offer one word; it leaves at the rising edge where tready is high
  task automatic send_word(input logic [287:0] d);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic idle_sender();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_field(input int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3) : 32'h80000000 + $urandom_range(3);
      2: return $signed($urandom_range(2000000)) - 32'sd1000000;
      default: return {{14{$urandom_range(1) ? 1'b1 : 1'b0}}, 18'($urandom())};
    endcase
  endfunction

  function automatic logic [287:0] rnd_word();
    logic [287:0] d;
    for (int f = 0; f < 9; f++) d[f*32 +: 32] = rnd_field($urandom_range(3));
    return d;
  endfunction

  // build a word from fields, point first
  function automatic logic [287:0] mk(input logic [31:0] p0, p1, p2, v0, v1, v2, a0, a1, a2);
    return {a2, a1, a0, v2, v1, v0, p2, p1, p0};
  endfunction

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct; recv_stall_pct = stall_pct;
    repeat (n) send_word(rnd_word());
    idle_sender();
  endtask

  initial begin
    logic [31:0] one, mx, mn, pi_q, deg90;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_recv = 1'b0; angle_unit = 1'b0; words_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    one = 32'h0001_0000; mx = 32'h7FFFFFFF; mn = 32'h80000000;
    pi_q = 32'h0003_243F; deg90 = 32'h005A_0000;

    // directed, radians: zero angles, extreme coordinates, wrap, saturation
    send_word('0);
    send_word(mk(mx, mn, mx, mn, mx, mn, 0, 0, 0));
    send_word(mk(mx, mx, mx, mn, mn, mn, pi_q, 0, 0));
    send_word(mk(mn, mn, mn, mx, mx, mx, 0, pi_q, pi_q));
    send_word(mk(one, 0, 0, 0, 0, 0, 0, 0, pi_q >> 1));
    send_word(mk(0, one, 0, 0, 0, 0, pi_q >> 1, 0, 0));
    send_word(mk(0, 0, one, 0, 0, 0, 0, pi_q >> 1, 0));
    send_word(mk(one, one, one, one, one, one, mx, mn, mx));
    send_word(mk(32'h12345678, 32'h9ABCDEF0, one, 0, 0, 0, mn, mn, mn));
    send_word(mk(mx, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 1, 32'hFFFF0000));
    send_word({288{1'b1}});
    idle_sender();

    // directed, degrees
    set_unit(1'b1);
    send_word(mk(one, 0, 0, 0, 0, 0, 0, 0, deg90));
    send_word(mk(one, one, one, 0, 0, 0, deg90, deg90, deg90));
    send_word(mk(mx, mx, 0, 0, 0, 0, 0, 0, 32'h002D_0000));
    send_word(mk(one, 0, 0, mn, mx, 0, mx, mn, 32'h0168_0000));
    send_word(mk(mn, mx, mn, one, one, one, 32'hFE98_0000, 32'h00B4_0000, mx));
    idle_sender();

    // random phases across units and flow patterns
    set_unit(1'b0);
    run_phase(100, 0, 0);
    run_phase(90, 55, 0);
    // receiver held off while the sender keeps offering; fills the pipe
    hold_recv = 1'b1;
    run_phase(90, 0, 55);
    run_phase(90, 8, 8);
    // sender pauses until everything has drained
    while (pending != 0) @(posedge clk_i);
    set_unit(1'b1);
    run_phase(100, 0, 0);
    run_phase(90, 55, 0);
    run_phase(90, 0, 55);
    run_phase(90, 8, 8);
    set_unit(1'b0);
    run_phase(20, 8, 8);

    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d words in both angle units, %0d saturated results", seen, sat_seen);
    $display("flow phases: free run, sender gaps, receiver stalls, both, long hold-off");
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rppx_pkg.sv
sv/rotate_point_about_pivot_xyz.sv
tb/rppx_checker.sv
tb/tb_rotate_point_about_pivot_xyz.sv
